>>> rtl/core/crypto_unit_dispatch_arbiter_core_assert.svh
// Assertion macros for the crypto unit dispatch arbiter core
`ifndef CRYPTO_UNIT_DISPATCH_ARBITER_CORE_ASSERT_SVH
`define CRYPTO_UNIT_DISPATCH_ARBITER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define CUDA_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cuda: same-cycle check failed");

// Next-cycle implication, sampled on clk_i, off during reset
`define CUDA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cuda: next-cycle check failed");

`endif

>>> rtl/core/cuda_pkg.sv
// Shared types, constants and helper functions of the crypto unit dispatch arbiter
`timescale 1ns / 1ps
package cuda_pkg;

  // Pool sizes and busy counter width
  localparam int unsigned MAX_ENC_UNITS  = 8;
  localparam int unsigned MAX_AUTH_UNITS = 8;
  localparam int unsigned BUSY_WIDTH     = 8;

  // One pool module serves both kinds; it is sized for the larger one
  localparam int unsigned UNIT_MAX = (MAX_ENC_UNITS > MAX_AUTH_UNITS) ?
                                     MAX_ENC_UNITS : MAX_AUTH_UNITS;
  localparam int unsigned IDX_W    = (UNIT_MAX > 1) ? $clog2(UNIT_MAX) : 1;
  localparam int unsigned CNT_W    = $clog2(UNIT_MAX + 1);

  localparam int unsigned BUSY_MAX = (1 << BUSY_WIDTH) - 1;
  localparam int unsigned LOAD_W   = (BUSY_WIDTH > 8) ? BUSY_WIDTH : 8;

  // Field widths of the ports
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned TAG_W      = 16;
  localparam int unsigned UIDX_W     = 3;
  localparam int unsigned UCNT_W     = 4;

  // Result buffer
  localparam int unsigned RBUF_DEPTH = 4;
  localparam int unsigned RBUF_PTR_W = $clog2(RBUF_DEPTH);
  localparam int unsigned RBUF_CNT_W = $clog2(RBUF_DEPTH + 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENC_BUSY_CYCLES  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_AUTH_BUSY_CYCLES = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_ENC_UNIT_COUNT   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_AUTH_UNIT_COUNT  = CFG_IDX_W'(3);

  // Unit kinds
  localparam logic KIND_ENC  = 1'b0;
  localparam logic KIND_AUTH = 1'b1;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_APP  = 2'd1,
    CMD_EXIT = 2'd2,
    CMD_NET  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_ENCRYPT      = 2'd0,
    OP_AUTHENTICATE = 2'd1,
    OP_DECRYPT      = 2'd2,
    OP_VERIFY       = 2'd3
  } op_e;

  typedef logic [BUSY_WIDTH-1:0] busy_t;

  // Pool control: count down on a tick, or load the lowest free unit
  typedef struct packed {
    logic  tick;
    logic  take;
    busy_t load;
  } pool_ctl_t;

  // Pool status: lowest free unit now, free units after a tick
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] free_cnt;
  } pool_stat_t;

  // One result beat
  typedef struct packed {
    logic              unit_kind;
    logic [UIDX_W-1:0] unit_index;
    op_e               operation;
    logic [TAG_W-1:0]  tag_out;
    logic              dropped;
    logic              grant_exit;
    logic              grant_net;
    logic              grant_app;
    logic              is_tick_result;
    logic              last;
  } rec_t;

  // Busy time to load: zero counts as one, clip to the counter range
  function automatic busy_t load_value(input logic [CFG_DATA_W-1:0] c);
    logic [LOAD_W-1:0] v;
    v = LOAD_W'(c);
    if (v == '0) v = LOAD_W'(1);
    if (v > LOAD_W'(BUSY_MAX)) v = LOAD_W'(BUSY_MAX);
    return BUSY_WIDTH'(v);
  endfunction

  // Units in use, clipped to the pool size of that kind
  function automatic logic [CNT_W-1:0] sat_count(input logic [UCNT_W-1:0] c,
                                                 input int unsigned mx);
    if (32'(c) > mx) return CNT_W'(mx);
    return CNT_W'(c);
  endfunction

endpackage

>>> rtl/core/cuda_pool.sv
// One pool of crypto units: busy counters, lowest free search, free count
`timescale 1ns / 1ps
module cuda_pool (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cuda_pkg::pool_ctl_t   ctl_i,
  input  logic [cuda_pkg::CNT_W-1:0] n_active_i,
  output cuda_pkg::pool_stat_t  stat_o
);
  import cuda_pkg::*;

  busy_t               busy_q [UNIT_MAX];
  busy_t               busy_d [UNIT_MAX];
  logic [UNIT_MAX-1:0] free_now;
  logic [UNIT_MAX-1:0] free_after_tick;
  logic [IDX_W-1:0]    low_idx;

  // Flag free units among those in use
  always_comb begin
    for (int i = 0; i < UNIT_MAX; i++) begin
      free_now[i]        = (CNT_W'(i) < n_active_i) && (busy_q[i] == '0);
      free_after_tick[i] = (CNT_W'(i) < n_active_i) && (busy_q[i] <= busy_t'(1));
    end
  end

  // Pick the lowest free unit
  always_comb begin
    low_idx = '0;
    for (int i = UNIT_MAX - 1; i >= 0; i--) begin
      if (free_now[i]) low_idx = IDX_W'(i);
    end
  end

  assign stat_o.found    = |free_now;
  assign stat_o.idx      = low_idx;
  assign stat_o.free_cnt = CNT_W'($countones(free_after_tick));

  // Count down on a tick, load the chosen unit on a dispatch
  always_comb begin
    for (int i = 0; i < UNIT_MAX; i++) begin
      busy_d[i] = busy_q[i];
      if (ctl_i.tick && (busy_q[i] != '0)) begin
        busy_d[i] = busy_q[i] - busy_t'(1);
      end else if (ctl_i.take && (low_idx == IDX_W'(i))) begin
        busy_d[i] = ctl_i.load;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < UNIT_MAX; i++) busy_q[i] <= '0;
    end else begin
      for (int i = 0; i < UNIT_MAX; i++) busy_q[i] <= busy_d[i];
    end
  end

endmodule

>>> rtl/core/cuda_rbuf.sv
// Result buffer: takes one or two beats per cycle while it has room, hands out one per cycle while the reader takes it
`timescale 1ns / 1ps
module cuda_rbuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic          pair_i,
  input  cuda_pkg::rec_t rec0_i,
  input  cuda_pkg::rec_t rec1_i,
  output logic          room_o,
  output logic          valid_o,
  input  logic          pop_i,
  output cuda_pkg::rec_t rec_o
);
  import cuda_pkg::*;

  rec_t                  mem_q [RBUF_DEPTH];
  logic [RBUF_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [RBUF_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [RBUF_CNT_W-1:0] cnt_q, cnt_d;
  logic [RBUF_CNT_W-1:0] n_push;
  logic                  pop;

  // Room for a full pair is needed before the next beat in
  assign room_o  = cnt_q <= RBUF_CNT_W'(RBUF_DEPTH - 2);
  assign valid_o = cnt_q != '0;
  assign rec_o   = mem_q[rd_ptr_q];
  assign pop     = valid_o && pop_i;

  // Advance pointers and fill level
  always_comb begin
    n_push   = push_i ? (pair_i ? RBUF_CNT_W'(2) : RBUF_CNT_W'(1)) : '0;
    wr_ptr_d = wr_ptr_q + RBUF_PTR_W'(n_push);
    rd_ptr_d = rd_ptr_q + RBUF_PTR_W'(pop);
    cnt_d    = cnt_q + n_push - RBUF_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store beats
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= rec0_i;
    if (push_i && pair_i) mem_q[wr_ptr_q + RBUF_PTR_W'(1)] <= rec1_i;
  end

endmodule

>>> rtl/core/crypto_unit_dispatch_arbiter_core.sv
// Top level of the crypto unit dispatch arbiter
`timescale 1ns / 1ps
`include "crypto_unit_dispatch_arbiter_core_assert.svh"
// Takes one beat per clock: a tick, which counts down the busy units and
// grants the waiting queues (exit, then net, then app), or a flit arrival,
// which goes to the lowest free unit of each kind it needs or is dropped.
// Every item is worked off in the cycle it is accepted, against the unit
// busy counters; its result beats (one, two for a dispatched net flit) are
// registered in a four-deep result buffer and reach the output behind
// earlier beats. The input takes an item whenever the buffer has room for
// two beats, so the sustained rate is one item per clock as long as the
// output drains one beat per clock; the output paces runs of net flits.
// Configuration writes are taken in any cycle (cfg_ready_o is tied high).
module crypto_unit_dispatch_arbiter_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [cuda_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [cuda_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input items
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      command_i,
  input  logic [cuda_pkg::TAG_W-1:0]      flit_tag_i,
  input  logic                            exit_waiting_i,
  input  logic                            net_waiting_i,
  input  logic                            app_waiting_i,
  // results
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            unit_kind_o,
  output logic [cuda_pkg::UIDX_W-1:0]     unit_index_o,
  output logic [1:0]                      operation_o,
  output logic [cuda_pkg::TAG_W-1:0]      tag_out_o,
  output logic                            dropped_o,
  output logic                            grant_exit_o,
  output logic                            grant_net_o,
  output logic                            grant_app_o,
  output logic                            is_tick_result_o,
  output logic                            last_o
);
  import cuda_pkg::*;

  logic [CFG_DATA_W-1:0] enc_busy_cycles_q, auth_busy_cycles_q;
  logic [UCNT_W-1:0]     enc_unit_count_q, auth_unit_count_q;

  logic             acc;
  cmd_e             cmd;
  logic [CNT_W-1:0] n_enc, n_auth;
  pool_ctl_t        enc_ctl, auth_ctl;
  pool_stat_t       enc_stat, auth_stat;
  logic             net_ok;
  logic             g_exit, g_net, g_app;
  rec_t             rec0, rec1, rec_out;
  logic             pair;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_busy_cycles_q  <= CFG_DATA_W'(1);
      auth_busy_cycles_q <= CFG_DATA_W'(1);
      enc_unit_count_q   <= UCNT_W'(8);
      auth_unit_count_q  <= UCNT_W'(8);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ENC_BUSY_CYCLES:  enc_busy_cycles_q  <= cfg_data_i;
        REG_AUTH_BUSY_CYCLES: auth_busy_cycles_q <= cfg_data_i;
        REG_ENC_UNIT_COUNT:   enc_unit_count_q   <= cfg_data_i[UCNT_W-1:0];
        REG_AUTH_UNIT_COUNT:  auth_unit_count_q  <= cfg_data_i[UCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Accept and decode
  assign acc    = in_valid_i && in_ready_o;
  assign cmd    = cmd_e'(command_i);
  assign n_enc  = sat_count(enc_unit_count_q, MAX_ENC_UNITS);
  assign n_auth = sat_count(auth_unit_count_q, MAX_AUTH_UNITS);
  assign net_ok = enc_stat.found && auth_stat.found;

  // Drive the pools
  always_comb begin
    enc_ctl.tick  = acc && (cmd == CMD_TICK);
    auth_ctl.tick = acc && (cmd == CMD_TICK);
    enc_ctl.take  = acc && (((cmd == CMD_APP) && enc_stat.found) ||
                            ((cmd == CMD_NET) && net_ok));
    auth_ctl.take = acc && (((cmd == CMD_EXIT) && auth_stat.found) ||
                            ((cmd == CMD_NET) && net_ok));
    enc_ctl.load  = load_value(enc_busy_cycles_q);
    auth_ctl.load = load_value(auth_busy_cycles_q);
  end

  cuda_pool u_enc_pool (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (enc_ctl),
    .n_active_i (n_enc),
    .stat_o     (enc_stat)
  );

  cuda_pool u_auth_pool (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (auth_ctl),
    .n_active_i (n_auth),
    .stat_o     (auth_stat)
  );

  // Grant queues in priority order against the free counts after the tick
  always_comb begin
    g_exit = exit_waiting_i && (auth_stat.free_cnt != '0);
    g_net  = net_waiting_i && (enc_stat.free_cnt != '0) &&
             (auth_stat.free_cnt > CNT_W'(g_exit));
    g_app  = app_waiting_i && (enc_stat.free_cnt > CNT_W'(g_net));
  end

  // Build result beats
  always_comb begin
    rec0         = '0;
    rec1         = '0;
    pair         = 1'b0;
    rec0.tag_out = flit_tag_i;
    rec0.last    = 1'b1;
    unique case (cmd)
      CMD_TICK: begin
        rec0.tag_out        = '0;
        rec0.grant_exit     = g_exit;
        rec0.grant_net      = g_net;
        rec0.grant_app      = g_app;
        rec0.is_tick_result = 1'b1;
      end
      CMD_APP: begin
        rec0.unit_kind  = KIND_ENC;
        rec0.unit_index = enc_stat.found ? UIDX_W'(enc_stat.idx) : '0;
        rec0.operation  = OP_ENCRYPT;
        rec0.dropped    = !enc_stat.found;
      end
      CMD_EXIT: begin
        rec0.unit_kind  = auth_stat.found ? KIND_AUTH : KIND_ENC;
        rec0.unit_index = auth_stat.found ? UIDX_W'(auth_stat.idx) : '0;
        rec0.operation  = OP_AUTHENTICATE;
        rec0.dropped    = !auth_stat.found;
      end
      CMD_NET: begin
        rec0.unit_kind  = KIND_ENC;
        rec0.unit_index = net_ok ? UIDX_W'(enc_stat.idx) : '0;
        rec0.operation  = OP_DECRYPT;
        rec0.dropped    = !net_ok;
        rec0.last       = !net_ok;
        rec1.unit_kind  = KIND_AUTH;
        rec1.unit_index = UIDX_W'(auth_stat.idx);
        rec1.operation  = OP_VERIFY;
        rec1.tag_out    = flit_tag_i;
        rec1.last       = 1'b1;
        pair            = net_ok;
      end
      default: ;
    endcase
  end

  cuda_rbuf u_rbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (acc),
    .pair_i  (pair),
    .rec0_i  (rec0),
    .rec1_i  (rec1),
    .room_o  (in_ready_o),
    .valid_o (out_valid_o),
    .pop_i   (out_ready_i),
    .rec_o   (rec_out)
  );

  // Unpack the output beat
  assign unit_kind_o      = rec_out.unit_kind;
  assign unit_index_o     = rec_out.unit_index;
  assign operation_o      = rec_out.operation;
  assign tag_out_o        = rec_out.tag_out;
  assign dropped_o        = rec_out.dropped;
  assign grant_exit_o     = rec_out.grant_exit;
  assign grant_net_o      = rec_out.grant_net;
  assign grant_app_o      = rec_out.grant_app;
  assign is_tick_result_o = rec_out.is_tick_result;
  assign last_o           = rec_out.last;

  // Checks
  `CUDA_ASSERT_NEXT(a_pair_second_beat_held, out_valid_o && out_ready_i && !last_o, out_valid_o)
  `CUDA_ASSERT_IMPLIES(a_drop_not_tick, out_valid_o && dropped_o, !is_tick_result_o)
  `CUDA_ASSERT_IMPLIES(a_stall_has_output, !in_ready_o, out_valid_o)
  `CUDA_ASSERT_IMPLIES(a_take_not_on_tick, enc_ctl.take || auth_ctl.take, !enc_ctl.tick)

endmodule
